[hdl/rpa_pkg.sv]
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and codes of the rectangle pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package rpa_pkg;

	localparam int unsigned DIM_BITS = 12;
	localparam int unsigned REG_W    = DIM_BITS + 1;
	localparam int unsigned POS_W    = DIM_BITS;
	localparam int unsigned CNT_W    = 16;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_SIZE = 2'd1,
		ST_NO_FIT   = 2'd2,
		ST_FULL     = 2'd3
	} res_code_t;

	typedef enum logic {
		OP_REQUEST = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic {
		REG_POOL_WIDTH  = 1'b0,
		REG_POOL_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic      load_in;
		logic      pass_start;
		logic      pass_fit;
		logic      from_cur;
		logic      mul;
		logic      split;
		logic      next_piece;
		logic      append;
		logic      commit;
		logic      finish;
		res_code_t code;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_rel;
		logic bad_size;
		logic piece_zero;
		logic pass_done;
		logic hit;
		logic full;
		logic has_b;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

[hdl/rpa_ctrl.sv]
// ----------------------------------------------------------------------------
// rpa_ctrl
// Sequencer: fit scan, split, merge passes, append, commit and result.
// ----------------------------------------------------------------------------
`default_nettype none

module rpa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output rpa_pkg::ctl_cmd_t      cmd,
	input  wire rpa_pkg::dp_stat_t st
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_FIT, S_MUL, S_SPLIT, S_PIECE, S_MRG, S_APPEND, S_FINISH
	} state_t;

	state_t              state_q, state_d;
	rpa_pkg::res_code_t  code_q, code_d;

	always_comb begin
		cmd      = '0;
		cmd.code = code_q;
		state_d  = state_q;
		code_d   = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (st.is_rel) begin
					if (st.piece_zero) begin
						code_d  = rpa_pkg::ST_OK;
						state_d = S_FINISH;
					end else begin
						cmd.pass_start = 1'b1;
						cmd.from_cur   = 1'b1;
						state_d        = S_MRG;
					end
				end else if (st.bad_size) begin
					code_d  = rpa_pkg::ST_BAD_SIZE;
					state_d = S_FINISH;
				end else begin
					cmd.pass_start = 1'b1;
					cmd.pass_fit   = 1'b1;
					cmd.from_cur   = 1'b1;
					state_d        = S_FIT;
				end
			end
			S_FIT: begin
				if (st.pass_done) begin
					if (st.hit) begin
						state_d = S_MUL;
					end else begin
						code_d  = rpa_pkg::ST_NO_FIT;
						state_d = S_FINISH;
					end
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SPLIT;
			end
			S_SPLIT: begin
				cmd.split = 1'b1;
				state_d   = S_PIECE;
			end
			S_PIECE: begin
				if (st.piece_zero) begin
					if (st.has_b) begin
						cmd.next_piece = 1'b1;
					end else begin
						cmd.commit = 1'b1;
						code_d     = rpa_pkg::ST_OK;
						state_d    = S_FINISH;
					end
				end else begin
					cmd.pass_start = 1'b1;
					state_d        = S_MRG;
				end
			end
			S_MRG: begin
				if (st.pass_done) begin
					if (st.hit) begin
						cmd.pass_start = 1'b1;
					end else begin
						state_d = S_APPEND;
					end
				end
			end
			S_APPEND: begin
				cmd.append = 1'b1;
				if (st.full) begin
					cmd.commit = st.is_rel;
					code_d     = rpa_pkg::ST_FULL;
					state_d    = S_FINISH;
				end else if (!st.is_rel && st.has_b) begin
					cmd.next_piece = 1'b1;
					state_d        = S_PIECE;
				end else begin
					cmd.commit = 1'b1;
					code_d     = rpa_pkg::ST_OK;
					state_d    = S_FINISH;
				end
			end
			S_FINISH: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			code_q   <= rpa_pkg::ST_OK;
			in_ready <= 1'b1;
		end else begin
			state_q  <= state_d;
			code_q   <= code_d;
			in_ready <= (state_d == S_IDLE);
		end
	end

endmodule

`default_nettype wire

[hdl/rpa_dp.sv]
// ----------------------------------------------------------------------------
// rpa_dp
// Datapath: three-bank free list memory, list pass engine, split math,
// configuration registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpa_dp #(
	parameter int unsigned MAX_FREE = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rpa_pkg::ctl_cmd_t            cmd,
	output rpa_pkg::dp_stat_t                 st,
	input  wire logic                         operation,
	input  wire logic [rpa_pkg::POS_W-1:0]    pos_x,
	input  wire logic [rpa_pkg::POS_W-1:0]    pos_y,
	input  wire logic [rpa_pkg::REG_W-1:0]    size_w,
	input  wire logic [rpa_pkg::REG_W-1:0]    size_h,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic                         cfg_index,
	input  wire logic [rpa_pkg::REG_W-1:0]    cfg_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [1:0]                        status,
	output logic [rpa_pkg::POS_W-1:0]         place_x,
	output logic [rpa_pkg::POS_W-1:0]         place_y,
	output logic [rpa_pkg::CNT_W-1:0]         live_count
);

	localparam int unsigned D  = rpa_pkg::DIM_BITS + 1;
	localparam int unsigned AW = $clog2(MAX_FREE);
	localparam int unsigned NW = $clog2(MAX_FREE + 1);
	localparam int unsigned CW = (D > rpa_pkg::REG_W) ? D : rpa_pkg::REG_W;
	localparam int unsigned PW = 2 * D;

	typedef struct packed {
		logic [D-1:0] x;
		logic [D-1:0] y;
		logic [D-1:0] w;
		logic [D-1:0] h;
	} rect_t;

	rect_t mem_q [3][MAX_FREE];

	logic [rpa_pkg::REG_W-1:0] pool_w_q, pool_h_q, w_q, h_q;
	logic                      op_q;
	rect_t                     piece_q, pieceb_q, hit_rect_q, r_q, rd_data_s1;
	logic                      has_b_q, hit_q, fit_q, busy_q, done_q, vld_s1, fresh_s1, fresh_q;
	logic [1:0]                cur_bank_q, src_q, dst_q;
	logic [NW-1:0]             cur_cnt_q, n_q, rd_idx_q, wr_idx_q, cnt_q;
	logic [PW-1:0]             prod1_q, prod2_q;
	logic [rpa_pkg::CNT_W-1:0] granted_q;

	rect_t        ent, join_r, fresh_r;
	logic [D-1:0] xw, yh, wt, ht, w1, h2;
	logic         fit_ok, vert, horz, match, full, tall, eq_w, eq_h, pass_wr;
	logic         we;
	logic [1:0]   wbank;
	logic [AW-1:0] widx;
	rect_t        wdata;

	assign cfg_ready = 1'b1;
	assign fresh_r   = '{x: '0, y: '0, w: D'(pool_w_q), h: D'(pool_h_q)};
	assign ent       = fresh_s1 ? fresh_r : rd_data_s1;

	assign xw = piece_q.x + piece_q.w;
	assign yh = piece_q.y + piece_q.h;

	always_comb begin
		fit_ok = (CW'(ent.w) >= CW'(w_q)) && (CW'(ent.h) >= CW'(h_q));
		vert   = (ent.x == piece_q.x) && (ent.w == piece_q.w) &&
		         ((ent.y == yh) || (piece_q.y == D'(ent.y + ent.h)));
		horz   = (ent.y == piece_q.y) && (ent.h == piece_q.h) &&
		         ((ent.x == xw) || (piece_q.x == D'(ent.x + ent.w)));
		join_r = ent;
		if (vert) begin
			join_r.y = (ent.y > piece_q.y) ? piece_q.y : ent.y;
			join_r.h = ent.h + piece_q.h;
		end else begin
			join_r.x = (ent.x > piece_q.x) ? piece_q.x : ent.x;
			join_r.w = ent.w + piece_q.w;
		end
		match = fit_q ? fit_ok : (vert || horz);
	end

	assign full    = (cnt_q == NW'(MAX_FREE));
	assign pass_wr = busy_q && vld_s1 && !(!hit_q && match);

	always_comb begin
		we    = 1'b0;
		wbank = dst_q;
		widx  = wr_idx_q[AW-1:0];
		wdata = ent;
		if (pass_wr) begin
			we = 1'b1;
		end else if (cmd.append && !full) begin
			we    = 1'b1;
			widx  = cnt_q[AW-1:0];
			wdata = piece_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wbank][widx] <= wdata;
		end
		rd_data_s1 <= mem_q[src_q][rd_idx_q[AW-1:0]];
	end

	assign wt   = D'(w_q);
	assign ht   = D'(h_q);
	assign w1   = r_q.w - wt;
	assign h2   = r_q.h - ht;
	assign eq_w = (CW'(r_q.w) == CW'(w_q));
	assign eq_h = (CW'(r_q.h) == CW'(h_q));
	assign tall = (prod1_q > prod2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_w_q   <= rpa_pkg::REG_W'(4096);
			pool_h_q   <= rpa_pkg::REG_W'(4096);
			cur_cnt_q  <= NW'(1);
			fresh_q    <= 1'b1;
			cur_bank_q <= 2'd0;
			src_q      <= 2'd0;
			dst_q      <= 2'd1;
			op_q       <= rpa_pkg::OP_REQUEST;
			has_b_q    <= 1'b0;
			hit_q      <= 1'b0;
			fit_q      <= 1'b0;
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			vld_s1     <= 1'b0;
			fresh_s1   <= 1'b0;
			n_q        <= '0;
			rd_idx_q   <= '0;
			wr_idx_q   <= '0;
			cnt_q      <= '0;
			granted_q  <= '0;
			out_valid  <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			fresh_s1 <= fresh_q && (src_q == cur_bank_q);
			if (cfg_valid) begin
				if (cfg_index == rpa_pkg::REG_POOL_WIDTH) begin
					pool_w_q <= cfg_data;
				end else begin
					pool_h_q <= cfg_data;
				end
				cur_cnt_q <= NW'(1);
				fresh_q   <= 1'b1;
			end
			if (cmd.load_in) begin
				op_q    <= operation;
				w_q     <= size_w;
				h_q     <= size_h;
				piece_q <= '{x: D'(pos_x), y: D'(pos_y), w: D'(size_w), h: D'(size_h)};
			end
			if (cmd.pass_start) begin
				fit_q    <= cmd.pass_fit;
				rd_idx_q <= '0;
				wr_idx_q <= '0;
				hit_q    <= 1'b0;
				vld_s1   <= 1'b0;
				busy_q   <= 1'b1;
				if (cmd.from_cur) begin
					src_q <= cur_bank_q;
					dst_q <= (cur_bank_q == 2'd2) ? 2'd0 : cur_bank_q + 2'd1;
					n_q   <= cur_cnt_q;
				end else begin
					src_q <= dst_q;
					dst_q <= 2'd3 ^ cur_bank_q ^ dst_q;
					n_q   <= cnt_q;
				end
			end else if (busy_q) begin
				if (rd_idx_q < n_q) begin
					rd_idx_q <= rd_idx_q + NW'(1);
					vld_s1   <= 1'b1;
				end else begin
					vld_s1 <= 1'b0;
				end
				if (vld_s1) begin
					if (!hit_q && match) begin
						hit_q      <= 1'b1;
						hit_rect_q <= fit_q ? ent : join_r;
					end else begin
						wr_idx_q <= wr_idx_q + NW'(1);
					end
				end
				if ((rd_idx_q == n_q) && !vld_s1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					cnt_q  <= wr_idx_q;
					if (hit_q && fit_q) begin
						r_q <= hit_rect_q;
					end
					if (hit_q && !fit_q) begin
						piece_q <= hit_rect_q;
					end
				end
			end
			if (cmd.mul) begin
				prod1_q <= PW'(w1) * PW'(r_q.h);
				prod2_q <= PW'(h2) * PW'(r_q.w);
			end
			if (cmd.split) begin
				if (eq_w) begin
					piece_q <= '{x: r_q.x, y: r_q.y + ht, w: r_q.w, h: h2};
					has_b_q <= 1'b0;
				end else if (eq_h) begin
					piece_q <= '{x: r_q.x + wt, y: r_q.y, w: w1, h: r_q.h};
					has_b_q <= 1'b0;
				end else begin
					piece_q  <= '{x: r_q.x + wt, y: r_q.y, w: w1, h: tall ? r_q.h : ht};
					pieceb_q <= '{x: r_q.x, y: r_q.y + ht, w: tall ? wt : r_q.w, h: h2};
					has_b_q  <= 1'b1;
				end
			end
			if (cmd.next_piece) begin
				piece_q <= pieceb_q;
				has_b_q <= 1'b0;
			end
			if (cmd.append && !full) begin
				cnt_q <= cnt_q + NW'(1);
			end
			if (cmd.commit) begin
				cur_bank_q <= dst_q;
				cur_cnt_q  <= (cmd.append && !full) ? cnt_q + NW'(1) : cnt_q;
				fresh_q    <= 1'b0;
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (cmd.finish) begin
				out_valid <= 1'b1;
				status    <= cmd.code;
				if (op_q == rpa_pkg::OP_RELEASE) begin
					live_count <= (granted_q != '0) ? granted_q - 1'b1 : granted_q;
					granted_q  <= (granted_q != '0) ? granted_q - 1'b1 : granted_q;
					place_x    <= '0;
					place_y    <= '0;
				end else if (cmd.code == rpa_pkg::ST_OK) begin
					live_count <= (granted_q != '1) ? granted_q + 1'b1 : granted_q;
					granted_q  <= (granted_q != '1) ? granted_q + 1'b1 : granted_q;
					place_x    <= rpa_pkg::POS_W'(r_q.x);
					place_y    <= rpa_pkg::POS_W'(r_q.y);
				end else begin
					live_count <= granted_q;
					place_x    <= '0;
					place_y    <= '0;
				end
			end
		end
	end

	always_comb begin
		st            = '0;
		st.is_rel     = (op_q == rpa_pkg::OP_RELEASE);
		st.bad_size   = (w_q == '0) || (h_q == '0) || (w_q > pool_w_q) || (h_q > pool_h_q);
		st.piece_zero = (piece_q.w == '0) || (piece_q.h == '0);
		st.pass_done  = done_q;
		st.hit        = hit_q;
		st.full       = full;
		st.has_b      = has_b_q;
		st.out_free   = !out_valid || out_ready;
	end

endmodule

`default_nettype wire

[hdl/rectangle_pool_allocator_core.sv]
// ----------------------------------------------------------------------------
// rectangle_pool_allocator_core
// First-fit guillotine allocator over an ordered free rectangle list.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid/in_ready    | operation pos_x pos_y size_w size_h
//   out     | output    | out_valid/out_ready  | status place_x place_y live_count
//   cfg     | input     | cfg_valid/cfg_ready  | cfg_index cfg_data
//
// One item at a time. Each list pass streams n entries through the single
// read port of the list memory and then decides. A request is one fit pass
// plus, per nonzero piece, one merge pass per join and one more; a nonzero
// release is one pass per join plus one.
// Reset makes the list the single pool rectangle at once; no clearing pass.
// A result waiting on out_ready does not block accepting the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module rectangle_pool_allocator_core #(
	parameter int unsigned MAX_FREE = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      operation,
	input  wire logic [rpa_pkg::POS_W-1:0] pos_x,
	input  wire logic [rpa_pkg::POS_W-1:0] pos_y,
	input  wire logic [rpa_pkg::REG_W-1:0] size_w,
	input  wire logic [rpa_pkg::REG_W-1:0] size_h,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [1:0]                     status,
	output logic [rpa_pkg::POS_W-1:0]      place_x,
	output logic [rpa_pkg::POS_W-1:0]      place_y,
	output logic [rpa_pkg::CNT_W-1:0]      live_count,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic                      cfg_index,
	input  wire logic [rpa_pkg::REG_W-1:0] cfg_data
);

	rpa_pkg::ctl_cmd_t cmd;
	rpa_pkg::dp_stat_t st;

	rpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.st       (st)
	);

	rpa_dp #(
		.MAX_FREE (MAX_FREE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.operation  (operation),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.size_w     (size_w),
		.size_h     (size_h),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.place_x    (place_x),
		.place_y    (place_y),
		.live_count (live_count)
	);

endmodule

`default_nettype wire

[hdl/rpa_checker.sv]
// ----------------------------------------------------------------------------
// rpa_checker
// Port-level checks of the rectangle pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module rpa_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic [1:0]                status,
	input wire logic [rpa_pkg::POS_W-1:0] place_x,
	input wire logic [rpa_pkg::POS_W-1:0] place_y,
	input wire logic [rpa_pkg::CNT_W-1:0] live_count
);

	// failed items never report a placement
	a_fail_no_place: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != rpa_pkg::ST_OK) |-> (place_x == '0) && (place_y == '0))
		else $error("placement reported on failed item");

	// one item in flight: input closes after a transfer
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(live_count))
		else $error("result changed while stalled");

endmodule

bind rectangle_pool_allocator_core rpa_checker u_rpa_checker (.*);

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rectangle_pool_allocator_core. A behavioral copy of
// the first-fit guillotine free list predicts every result. The checker
// compares each output transfer with the oldest prediction. Directed tests
// cover the size limits, the split shapes, the count floor and a full list.
// A random test then runs well-formed request/release traffic with some noise
// over several pool settings, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NFREE = 64;

	typedef struct packed {
		logic [12:0] x;
		logic [12:0] y;
		logic [12:0] w;
		logic [12:0] h;
	} rect_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] px;
		logic [11:0] py;
		logic [15:0] cnt;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = 1'b0;
	logic [11:0] pos_x = '0;
	logic [11:0] pos_y = '0;
	logic [12:0] size_w = '0;
	logic [12:0] size_h = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [11:0] place_x;
	logic [11:0] place_y;
	logic [15:0] live_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [12:0] cfg_data = '0;

	rectangle_pool_allocator_core dut (.*);

	always #5 clk = ~clk;

	// predictor state
	rect_t free_list[NFREE];
	int unsigned free_cnt;
	rect_t scratch[NFREE];
	int unsigned scratch_cnt;
	logic [12:0] pool_w, pool_h;
	logic [15:0] granted;

	outcome_t pending_q[$];
	rect_t live_q[$];
	int errors = 0;
	int burst_left = 0;
	int hold_left = 0;

	function automatic void scratch_drop(int unsigned i);
		for (int unsigned k = i; k + 1 < scratch_cnt; k++)
			scratch[k] = scratch[k + 1];
		scratch_cnt--;
	endfunction

	function automatic bit absorb(rect_t r);
		rect_t m;
		bit joined;
		logic [12:0] xw, yh;
		if (r.w == 0 || r.h == 0) return 1'b1;
		joined = 1'b1;
		while (joined) begin
			xw = r.x + r.w;
			yh = r.y + r.h;
			joined = 1'b0;
			for (int unsigned i = 0; i < scratch_cnt; i++) begin
				m = scratch[i];
				if (m.x == r.x && m.w == r.w && (m.y == yh || r.y == 13'(m.y + m.h))) begin
					if (m.y > r.y) m.y = r.y;
					m.h = m.h + r.h;
					scratch_drop(i); r = m; joined = 1'b1; break;
				end else if (m.y == r.y && m.h == r.h &&
						(m.x == xw || r.x == 13'(m.x + m.w))) begin
					if (m.x > r.x) m.x = r.x;
					m.w = m.w + r.w;
					scratch_drop(i); r = m; joined = 1'b1; break;
				end
			end
		end
		if (scratch_cnt >= NFREE) return 1'b0;
		scratch[scratch_cnt] = r;
		scratch_cnt++;
		return 1'b1;
	endfunction

	function automatic void pool_reset();
		for (int i = 0; i < NFREE; i++) free_list[i] = '0;
		free_list[0].w = pool_w;
		free_list[0].h = pool_h;
		free_cnt = 1;
	endfunction

	function automatic outcome_t allocate(rpa_pkg::op_t op, logic [11:0] px, logic [11:0] py,
			logic [12:0] w, logic [12:0] h);
		outcome_t e;
		rect_t r, a, b;
		bit found, fit, tall;
		logic [12:0] w1, h2;
		e = '0;
		scratch = free_list;
		scratch_cnt = free_cnt;
		if (op == rpa_pkg::OP_REQUEST) begin
			if (w == 0 || h == 0 || w > pool_w || h > pool_h) begin
				e.status = rpa_pkg::ST_BAD_SIZE;
			end else begin
				found = 1'b0;
				r = '0;
				for (int unsigned i = 0; i < scratch_cnt; i++) begin
					if (scratch[i].w >= w && scratch[i].h >= h) begin
						r = scratch[i]; scratch_drop(i); found = 1'b1; break;
					end
				end
				if (!found) begin
					e.status = rpa_pkg::ST_NO_FIT;
				end else begin
					if (r.w == w) begin
						a = '{r.x, 13'(r.y + h), r.w, 13'(r.h - h)};
						fit = absorb(a);
					end else if (r.h == h) begin
						a = '{13'(r.x + w), r.y, 13'(r.w - w), r.h};
						fit = absorb(a);
					end else begin
						w1 = r.w - w;
						h2 = r.h - h;
						tall = (27'(w1) * 27'(r.h)) > (27'(h2) * 27'(r.w));
						a = '{13'(r.x + w), r.y, w1, tall ? r.h : h};
						b = '{r.x, 13'(r.y + h), tall ? w : r.w, h2};
						fit = absorb(a);
						if (fit) fit = absorb(b);
					end
					if (!fit) begin
						e.status = rpa_pkg::ST_FULL;
					end else begin
						free_list = scratch;
						free_cnt = scratch_cnt;
						e.px = r.x[11:0];
						e.py = r.y[11:0];
						if (granted != 16'hFFFF) granted++;
					end
				end
			end
		end else begin
			if (granted != 0) granted--;
			if (!absorb('{13'(px), 13'(py), w, h})) e.status = rpa_pkg::ST_FULL;
			free_list = scratch;
			free_cnt = scratch_cnt;
		end
		e.cnt = granted;
		return e;
	endfunction

	task automatic send_item(rpa_pkg::op_t op, logic [11:0] px, logic [11:0] py,
			logic [12:0] w, logic [12:0] h);
		int gap;
		outcome_t e;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		operation = op;
		pos_x = px;
		pos_y = py;
		size_w = w;
		size_h = h;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		e = allocate(op, px, py, w, h);
		pending_q.push_back(e);
		if (op == rpa_pkg::OP_REQUEST && e.status == rpa_pkg::ST_OK)
			live_q.push_back('{13'(e.px), 13'(e.py), w, h});
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(rpa_pkg::reg_idx_t idx, logic [12:0] val);
		drain();
		@(negedge clk);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == rpa_pkg::REG_POOL_WIDTH) pool_w = val;
		else pool_h = val;
		pool_reset();
		live_q.delete();
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_pool(logic [12:0] w, logic [12:0] h);
		write_reg(rpa_pkg::REG_POOL_WIDTH, w);
		write_reg(rpa_pkg::REG_POOL_HEIGHT, h);
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			case ($urandom_range(0, 5))
				0, 1, 2: out_ready = 1'b1;
				3, 4:    out_ready = $urandom_range(0, 1);
				default: out_ready = 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, status);
					errors++;
				end
				if (place_x !== e.px) begin
					$error("place_x expected %0d actual %0d", e.px, place_x);
					errors++;
				end
				if (place_y !== e.py) begin
					$error("place_y expected %0d actual %0d", e.py, place_y);
					errors++;
				end
				if (live_count !== e.cnt) begin
					$error("live_count expected %0d actual %0d", e.cnt, live_count);
					errors++;
				end
			end
		end
	end

	task automatic test_limits();
		send_item(rpa_pkg::OP_REQUEST, 0, 0, 0, 5);
		send_item(rpa_pkg::OP_REQUEST, 0, 0, 5, 0);
		send_item(rpa_pkg::OP_REQUEST, 0, 0, 4097, 1);
		send_item(rpa_pkg::OP_REQUEST, 0, 0, 1, 8191);
		send_item(rpa_pkg::OP_REQUEST, 12'hFFF, 12'hFFF, 4096, 4096);
		send_item(rpa_pkg::OP_REQUEST, 0, 0, 1, 1);
		send_item(rpa_pkg::OP_RELEASE, 0, 0, 4096, 4096);
		send_item(rpa_pkg::OP_REQUEST, 0, 0, 4096, 1);
		send_item(rpa_pkg::OP_REQUEST, 0, 0, 1, 4095);
		send_item(rpa_pkg::OP_RELEASE, 12'hFFF, 12'hFFF, 8191, 8191);
		send_item(rpa_pkg::OP_RELEASE, 0, 0, 0, 0);
	endtask

	task automatic test_split();
		set_pool(100, 60);
		send_item(rpa_pkg::OP_REQUEST, 0, 0, 30, 20);
		send_item(rpa_pkg::OP_REQUEST, 0, 0, 90, 5);
		send_item(rpa_pkg::OP_REQUEST, 0, 0, 70, 60);
		send_item(rpa_pkg::OP_REQUEST, 0, 0, 30, 40);
		send_item(rpa_pkg::OP_RELEASE, 0, 0, 30, 20);
		send_item(rpa_pkg::OP_RELEASE, 30, 0, 70, 60);
		send_item(rpa_pkg::OP_REQUEST, 0, 0, 100, 60);
	endtask

	task automatic test_count_floor();
		set_pool(8, 8);
		send_item(rpa_pkg::OP_RELEASE, 0, 0, 8, 8);
		send_item(rpa_pkg::OP_RELEASE, 0, 0, 8, 8);
		send_item(rpa_pkg::OP_REQUEST, 0, 0, 8, 8);
		send_item(rpa_pkg::OP_REQUEST, 0, 0, 8, 8);
	endtask

	task automatic test_list_full();
		set_pool(64, 64);
		for (int i = 0; i < 66; i++)
			send_item(rpa_pkg::OP_RELEASE, 12'(200 + 2 * i), 0, 1, 1);
		send_item(rpa_pkg::OP_REQUEST, 0, 0, 1, 1);
		send_item(rpa_pkg::OP_REQUEST, 0, 0, 64, 64);
	endtask

	task automatic test_backpressure();
		set_pool(32, 32);
		hold_left = 400;
		for (int i = 0; i < 20; i++)
			send_item(rpa_pkg::OP_REQUEST, 0, 0, 13'($urandom_range(1, 8)),
				13'($urandom_range(1, 8)));
	endtask

	task automatic test_random();
		logic [12:0] pw[6] = '{1, 4096, 16, 13'd40, 4096, 13'd256};
		logic [12:0] ph[6] = '{1, 4096, 16, 13'd24, 1, 13'd256};
		int pick;
		int idx;
		rect_t g;
		logic [12:0] w, h;
		for (int p = 0; p < 6; p++) begin
			set_pool(pw[p], ph[p]);
			for (int n = 0; n < 185; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					send_item(rpa_pkg::op_t'($urandom_range(0, 1)), 12'($urandom),
						12'($urandom), 13'($urandom), 13'($urandom));
				end else if (pick < 60 || live_q.size() == 0) begin
					if ($urandom_range(0, 3) == 0) begin
						w = 13'($urandom_range(1, pw[p]));
						h = 13'($urandom_range(1, ph[p]));
					end else begin
						w = 13'($urandom_range(1, (pw[p] + 3) / 4));
						h = 13'($urandom_range(1, (ph[p] + 3) / 4));
					end
					send_item(rpa_pkg::OP_REQUEST, 12'($urandom), 12'($urandom), w, h);
				end else begin
					idx = $urandom_range(0, live_q.size() - 1);
					g = live_q[idx];
					live_q.delete(idx);
					send_item(rpa_pkg::OP_RELEASE, g.x[11:0], g.y[11:0], g.w, g.h);
				end
			end
		end
	endtask

	initial begin
		pool_w = 4096;
		pool_h = 4096;
		granted = 0;
		pool_reset();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_limits();
		test_split();
		test_count_floor();
		test_list_full();
		test_backpressure();
		test_random();
		drain();
		if (errors == 0 && pending_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#500ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
